// ----- sv/dpq_pkg.sv -----
package dpq_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int WORD_W        = 32;
  localparam int POS_W         = 8;
  localparam int ACT_W         = 3;
  localparam int ST_W          = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_READ       = 3'd3,
    ACT_WRITE      = 3'd4,
    ACT_CLEAR      = 3'd5
  } dpq_action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } dpq_status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // carry out the captured action and load the result
  } dpq_cmd_t;

endpackage

// ----- sv/dpq_ram.sv -----
module dpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dpq_ctrl.sv -----
module dpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dpq_pkg::dpq_cmd_t cmd
);

  import dpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   exec_go;
  logic   out_valid_next;

  // Execute only when the result register is free or being emptied this cycle
  assign exec_go  = (state == S_EXEC) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = exec_go;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (exec_go) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC)
    else $error("accepted transaction did not move to execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> out_valid)
    else $error("executed action left no result");
`endif

endmodule

// ----- sv/dpq_datapath.sv -----
module dpq_datapath #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dpq_pkg::dpq_cmd_t                   cmd,
  input  logic [dpq_pkg::ACT_W-1:0]           action,
  input  logic signed [dpq_pkg::WORD_W-1:0]   value,
  input  logic [dpq_pkg::POS_W-1:0]           position,
  output logic signed [dpq_pkg::WORD_W-1:0]   word_out,
  output logic [dpq_pkg::ST_W-1:0]            status,
  output logic [$clog2(DEPTH+1)-1:0]          occupancy,
  output logic                                is_empty
);

  import dpq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OFS_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int SUM_W = OFS_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [AW-1:0]    LAST    = AW'(DEPTH - 1);

  // captured transaction
  logic [ACT_W-1:0]         action_q;
  logic [WORD_W-1:0]        value_q;
  logic [POS_W-1:0]         position_q;

  logic [AW-1:0]            front;
  logic [AW-1:0]            front_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [ST_W-1:0]          status_q;
  logic [ST_W-1:0]          status_next;
  logic                     word_sel;
  logic                     word_sel_next;

  logic                     full;
  logic                     empty;
  logic                     pos_ok;
  logic [OFS_W-1:0]         offset;
  logic [SUM_W-1:0]         slot_sum;
  logic [AW-1:0]            slot;
  logic [AW-1:0]            front_dec;
  logic [AW-1:0]            front_inc;

  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_addr;
  logic [WORD_W-1:0]        ram_rdata;

  assign full   = (count == DEPTH_C);
  assign empty  = (count == '0);
  assign pos_ok = (OFS_W'(position_q) < OFS_W'(count));

  // ring slot of an offset from the front; for the offsets acted on the sum stays below twice the depth
  assign offset   = (action_q == ACT_PUSH_BACK) ? OFS_W'(count) : OFS_W'(position_q);
  assign slot_sum = SUM_W'(front) + SUM_W'(offset);
  assign slot     = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);

  assign front_dec = (front == '0) ? LAST : front - AW'(1);
  assign front_inc = (front == LAST) ? '0 : front + AW'(1);

  always_comb begin
    front_next    = front;
    count_next    = count;
    status_next   = ST_OK;
    word_sel_next = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = slot;
    unique case (action_q)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + CNT_W'(1);
          ram_we     = 1'b1;
          ram_addr   = front_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          ram_we     = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          front_next    = front_inc;
          count_next    = count - CNT_W'(1);
          ram_re        = 1'b1;
          ram_addr      = front;
          word_sel_next = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_ok) begin
          ram_re        = 1'b1;
          word_sel_next = 1'b1;
        end else begin
          status_next = ST_RANGE;
        end
      end
      ACT_WRITE: begin
        if (pos_ok) begin
          ram_we = 1'b1;
        end else begin
          status_next = ST_RANGE;
        end
      end
      ACT_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: ;  // unused codes: no change
    endcase
  end

  dpq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we && cmd.exec),
    .waddr(ram_addr),
    .wdata(value_q),
    .re   (ram_re && cmd.exec),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q   <= action;
      value_q    <= value;
      position_q <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      status_q <= ST_OK;
      word_sel <= 1'b0;
    end else if (cmd.exec) begin
      front    <= front_next;
      count    <= count_next;
      status_q <= status_next;
      word_sel <= word_sel_next;
    end
  end

  // read data holds in the RAM output register until the next executed action
  assign word_out  = word_sel ? ram_rdata : '0;
  assign status    = status_q;
  assign occupancy = count;
  assign is_empty  = empty;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stored count exceeds depth");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (status_next == ST_FULL || status_next == ST_EMPTY
                 || status_next == ST_RANGE)
    |=> $stable(count) && $stable(front))
    else $error("refused action changed the ring");
`endif

endmodule

// ----- sv/double_ended_push_queue_core.sv -----
// Ring-buffer deque of up to DEPTH signed 32-bit words, addressed by a front
// pointer and a count. Each transaction carries one action (push front, push
// back, pop front, read at index, write at index, clear) and returns exactly
// one result with the word popped or read, a status, the count afterwards and
// an empty flag. Refused actions (pop when empty, push when full, index not
// below the count) leave the store untouched and report their status. A
// transaction is first captured; it is then executed once the result register
// is free or being emptied, and the word RAM is read or written and the
// pointers move. A new transaction is taken only after the current one has
// been executed. The RAM needs no clearing after reset.
module double_ended_push_queue_core #(
  parameter int DEPTH = dpq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dpq_pkg::ACT_W-1:0]           action,
  input  logic signed [dpq_pkg::WORD_W-1:0]   value,
  input  logic [dpq_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dpq_pkg::WORD_W-1:0]   word_out,
  output logic [dpq_pkg::ST_W-1:0]            status,
  output logic [$clog2(DEPTH+1)-1:0]          occupancy,
  output logic                                is_empty
);

  import dpq_pkg::*;

  dpq_cmd_t cmd;

  dpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  dpq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .action   (action),
    .value    (value),
    .position (position),
    .word_out (word_out),
    .status   (status),
    .occupancy(occupancy),
    .is_empty (is_empty)
  );

endmodule
